### design/tea_bd_pkg.sv
// Types, constants and round functions shared by the TEA block decrypt design.
package tea_bd_pkg;

   localparam int unsigned DEF_ROUND_COUNT = 32;
   localparam int unsigned WORD_W = 32;
   localparam int unsigned CSR_INDEX_W = 2;

   localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e3779b9;

   localparam logic [WORD_W-1:0] KEY0_RESET = 32'd128;
   localparam logic [WORD_W-1:0] KEY1_RESET = 32'd129;
   localparam logic [WORD_W-1:0] KEY2_RESET = 32'd130;
   localparam logic [WORD_W-1:0] KEY3_RESET = 32'd131;

   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD0 = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD1 = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD3 = 2'd3;

   typedef struct packed {
      logic [WORD_W-1:0] cipher_hi;
      logic [WORD_W-1:0] cipher_lo;
   } tea_req_type;

   typedef struct packed {
      logic [WORD_W-1:0] plain_hi;
      logic [WORD_W-1:0] plain_lo;
   } tea_rsp_type;

   function automatic logic [WORD_W-1:0] round_sum(input int unsigned rounds_left);
      logic [2*WORD_W-1:0] prod;
      prod = {{WORD_W{1'b0}}, TEA_DELTA} * (2*WORD_W)'(rounds_left);
      return prod[WORD_W-1:0];
   endfunction

   function automatic logic [WORD_W-1:0] mix_word(input logic [WORD_W-1:0] w,
                                                  input logic [WORD_W-1:0] sum,
                                                  input logic [WORD_W-1:0] ka,
                                                  input logic [WORD_W-1:0] kb);
      return ((w << 4) + ka) ^ (w + sum) ^ ((w >> 5) + kb);
   endfunction

endpackage

### design/tea_block_decrypt_top.sv
// Pipelined TEA decryption of one 64-bit block per cycle.
//
// Usage:
//   Input channel: drive req_data and raise start; the item is taken at any
//   clock edge where start is high and busy is low. busy stays low, so one
//   item may enter on every cycle.
//   Result channel: rsp_valid pulses for one cycle with rsp_data holding the
//   plaintext. Results leave in the order the items entered.
//   Key port: csr_valid/csr_ready with csr_index 0..3 selecting key words
//   0..3 and csr_data the value. csr_ready is always high. Write keys only
//   while no item is in flight.
// rsp_valid and rsp_data come straight from the registers of the last stage.
// One register stage per half round: each stage does one shift/add/xor mix
// and one subtract.
// Throughput: one item per cycle.
// Reset: clears every stage valid bit and loads the key reset values.
// The receiver cannot stall; every stage advances on every cycle.
module tea_block_decrypt_top
   import tea_bd_pkg::*;
#(
   parameter int unsigned ROUND_COUNT = DEF_ROUND_COUNT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  tea_req_type            req_data,
   output logic                   rsp_valid,
   output tea_rsp_type            rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]      csr_data
);

   localparam int unsigned STAGES = 2 * ROUND_COUNT;

   logic [WORD_W-1:0] key0_ff, key1_ff, key2_ff, key3_ff;

   logic [WORD_W-1:0] w0_ff [STAGES];
   logic [WORD_W-1:0] w1_ff [STAGES];
   logic              valid_ff [STAGES];
   logic [WORD_W-1:0] w0_in [STAGES];
   logic [WORD_W-1:0] w1_in [STAGES];
   logic              valid_in [STAGES];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff <= KEY0_RESET;
         key1_ff <= KEY1_RESET;
         key2_ff <= KEY2_RESET;
         key3_ff <= KEY3_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_KEY_WORD0: key0_ff <= csr_data;
            CSR_KEY_WORD1: key1_ff <= csr_data;
            CSR_KEY_WORD2: key2_ff <= csr_data;
            CSR_KEY_WORD3: key3_ff <= csr_data;
            default: ;
         endcase
      end
   end

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      localparam logic [WORD_W-1:0] SUM = round_sum(ROUND_COUNT - s / 2);

      logic [WORD_W-1:0] src_w0, src_w1;
      logic              src_valid;

      if (s == 0) begin : g_first
         assign src_w0    = req_data.cipher_lo;
         assign src_w1    = req_data.cipher_hi;
         assign src_valid = start && !busy;
      end else begin : g_next
         assign src_w0    = w0_ff[s-1];
         assign src_w1    = w1_ff[s-1];
         assign src_valid = valid_ff[s-1];
      end

      if (s % 2 == 0) begin : g_upd_w1
         always_comb begin
            w0_in[s] = src_w0;
            w1_in[s] = src_w1 - mix_word(src_w0, SUM, key2_ff, key3_ff);
         end
      end else begin : g_upd_w0
         always_comb begin
            w1_in[s] = src_w1;
            w0_in[s] = src_w0 - mix_word(src_w1, SUM, key0_ff, key1_ff);
         end
      end

      assign valid_in[s] = src_valid;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_in[s];
         end
         w0_ff[s] <= w0_in[s];
         w1_ff[s] <= w1_in[s];
      end
   end

   assign rsp_valid         = valid_ff[STAGES-1];
   assign rsp_data.plain_lo = w0_ff[STAGES-1];
   assign rsp_data.plain_hi = w1_ff[STAGES-1];

endmodule

### tb/tea_block_decrypt_top_test.sv
// Self-checking testbench for the pipelined TEA block decrypt top level.
module tea_block_decrypt_top_test
   import tea_bd_pkg::*;
;

   class tea_plain_board;
      logic [WORD_W-1:0] key [4];
      tea_rsp_type plain_due [$];
      int unsigned errors;
      int unsigned blocks_seen;

      function new();
         key[0] = KEY0_RESET;
         key[1] = KEY1_RESET;
         key[2] = KEY2_RESET;
         key[3] = KEY3_RESET;
         errors = 0;
         blocks_seen = 0;
      endfunction

      function void set_key(logic [CSR_INDEX_W-1:0] slot, logic [WORD_W-1:0] value);
         case (slot)
            CSR_KEY_WORD0: key[0] = value;
            CSR_KEY_WORD1: key[1] = value;
            CSR_KEY_WORD2: key[2] = value;
            CSR_KEY_WORD3: key[3] = value;
            default: ;
         endcase
      endfunction

      function logic [WORD_W-1:0] feistel_term(logic [WORD_W-1:0] w, logic [WORD_W-1:0] total,
                                               logic [WORD_W-1:0] ka, logic [WORD_W-1:0] kb);
         logic [WORD_W-1:0] lhs;
         logic [WORD_W-1:0] rhs;
         lhs = {w[WORD_W-5:0], 4'b0000} + ka;
         rhs = {5'b00000, w[WORD_W-1:5]} + kb;
         return lhs ^ (w + total) ^ rhs;
      endfunction

      function tea_rsp_type decrypt(tea_req_type blk);
         logic [WORD_W-1:0] v0;
         logic [WORD_W-1:0] v1;
         logic [WORD_W-1:0] total;
         tea_rsp_type plain;
         v0 = blk.cipher_lo;
         v1 = blk.cipher_hi;
         total = '0;
         repeat (DEF_ROUND_COUNT) total = total + TEA_DELTA;
         repeat (DEF_ROUND_COUNT) begin
            v1 = v1 - feistel_term(v0, total, key[2], key[3]);
            v0 = v0 - feistel_term(v1, total, key[0], key[1]);
            total = total - TEA_DELTA;
         end
         plain.plain_lo = v0;
         plain.plain_hi = v1;
         return plain;
      endfunction

      function void note_block(tea_req_type blk);
         plain_due.push_back(decrypt(blk));
         blocks_seen++;
      endfunction

      function void check_block(tea_rsp_type got);
         tea_rsp_type want;
         if (plain_due.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual %h", $time, got);
            errors++;
            return;
         end
         want = plain_due.pop_front();
         if (got.plain_lo !== want.plain_lo) begin
            $display("%0t: plain_lo mismatch: expected %h, actual %h",
                     $time, want.plain_lo, got.plain_lo);
            errors++;
         end
         if (got.plain_hi !== want.plain_hi) begin
            $display("%0t: plain_hi mismatch: expected %h, actual %h",
                     $time, want.plain_hi, got.plain_hi);
            errors++;
         end
      endfunction
   endclass

   localparam int unsigned CYCLE_LIMIT = 100000;
   localparam int unsigned PHASE_ITEMS = 270;
   localparam int unsigned LAST_PHASE = 6;
   localparam logic [CSR_INDEX_W-1:0] KEY_SLOT [4] =
      '{CSR_KEY_WORD0, CSR_KEY_WORD1, CSR_KEY_WORD2, CSR_KEY_WORD3};

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   tea_req_type            req_data;
   logic                   rsp_valid;
   tea_rsp_type            rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [WORD_W-1:0]      csr_data;

   tea_plain_board board = new();
   int unsigned cycles = 0;
   int unsigned key_settings = 1;

   tea_block_decrypt_top dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) board.note_block(req_data);
         if (rsp_valid) board.check_block(rsp_data);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, board.plain_due.size());
         $display("tea_block_decrypt_top_test: FAIL");
         $finish;
      end
   end

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return WORD_W'(1) << $urandom_range(0, WORD_W - 1);
         3: return ~(WORD_W'(1) << $urandom_range(0, WORD_W - 1));
         default: return $urandom;
      endcase
   endfunction

   task automatic send_block(input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi);
      @(negedge clock);
      start = 1'b1;
      req_data.cipher_lo = lo;
      req_data.cipher_hi = hi;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_gap(input int unsigned n);
      repeat (n) begin
         @(negedge clock);
         start = 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (board.plain_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_keys(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
                             input logic [WORD_W-1:0] k2, input logic [WORD_W-1:0] k3);
      logic [WORD_W-1:0] vals [4];
      vals = '{k0, k1, k2, k3};
      for (int i = 0; i < 4; i++) begin
         @(negedge clock);
         csr_valid = 1'b1;
         csr_index = KEY_SLOT[i];
         csr_data = vals[i];
         do @(posedge clock); while (!csr_ready);
         board.set_key(KEY_SLOT[i], vals[i]);
      end
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   initial begin
      logic [WORD_W-1:0] seed_lo [10];
      logic [WORD_W-1:0] seed_hi [10];
      bit gaps_on;

      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = CSR_KEY_WORD0;
      csr_data = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset keys, field extremes and bit patterns
      seed_lo = '{32'h0, 32'hffffffff, 32'h0, 32'hffffffff, 32'h80000000,
                  32'h7fffffff, 32'h1, 32'haaaaaaaa, 32'h55555555, 32'hdeadbeef};
      seed_hi = '{32'h0, 32'hffffffff, 32'hffffffff, 32'h0, 32'h80000000,
                  32'h7fffffff, 32'h1, 32'h55555555, 32'haaaaaaaa, 32'h01234567};
      for (int i = 0; i < 10; i++) send_block(seed_lo[i], seed_hi[i]);
      drain();

      for (int phase = 1; phase <= LAST_PHASE; phase++) begin
         case (phase)
            1: write_keys('0, '0, '0, '0);
            2: write_keys('1, '1, '1, '1);
            3: write_keys(32'h80000000, 32'h7fffffff, 32'h00000001, 32'hfffffffe);
            default: write_keys($urandom, $urandom, $urandom, $urandom);
         endcase
         key_settings++;
         if (phase <= 3) begin
            send_block('0, '0);
            send_block('1, '1);
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            gaps_on = (phase != LAST_PHASE) && ((n / 45) % 2 == 0);
            if (gaps_on && $urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 3));
            if (phase == 3 && n == PHASE_ITEMS / 2) drain();
            send_block(pick_word(), pick_word());
         end
         drain();
      end

      repeat (2 * DEF_ROUND_COUNT + 8) @(posedge clock);
      $display("Decrypted %0d blocks under %0d key settings (reset, all-zero, all-one, mixed).",
               board.blocks_seen, key_settings);
      $display("Back-to-back and gapped input, with a full drain mid-phase; %0d mismatches.",
               board.errors);
      if (board.errors == 0) begin
         $display("tea_block_decrypt_top_test: PASS");
      end else begin
         $display("tea_block_decrypt_top_test: FAIL");
      end
      $finish;
   end

endmodule

### tea_block_decrypt_top.f
design/tea_bd_pkg.sv
design/tea_block_decrypt_top.sv
tb/tea_block_decrypt_top_test.sv
